### sv/bdm_pkg.sv
`timescale 1ns / 1ps

package bdm_pkg;

  localparam int PIXEL_BITS     = 8;
  localparam int MAX_WIDTH_DEF  = 2048;
  localparam int CFG_BITS       = 12;
  localparam int ROW_BITS       = 12;
  localparam int MAX_RESULTS    = 4;

  localparam logic [CFG_BITS-1:0] WIDTH_RESET  = 12'd1440;
  localparam logic [CFG_BITS-1:0] HEIGHT_RESET = 12'd1080;

  localparam logic CFG_IDX_WIDTH  = 1'b0;
  localparam logic CFG_IDX_HEIGHT = 1'b1;

  // Window row selectors: two rows back, one row back, current row.
  localparam logic [1:0] ROW_OLD = 2'd0;
  localparam logic [1:0] ROW_MID = 2'd1;
  localparam logic [1:0] ROW_NEW = 2'd2;

  typedef logic [PIXEL_BITS-1:0] pix_t;
  typedef pix_t [2:0][2:0] win_t;

  typedef struct packed {
    logic x_first;
    logic last_col;
    logic last_row;
    logic y_ge1;
    logic y_eq1;
    logic y_odd;
    logic x_odd;
    pix_t pixel;
  } acc_t;

  typedef struct packed {
    pix_t red;
    pix_t green;
    pix_t blue;
    logic frame_end;
  } rgb_t;

  typedef rgb_t [MAX_RESULTS-1:0] rgb_arr_t;

  function automatic rgb_t emit_pix(win_t w, logic [1:0] ra, logic [1:0] rc,
                                    logic [1:0] rb, logic ye, logic xe, logic fe);
    logic [PIXEL_BITS+1:0] cross_sum;
    logic [PIXEL_BITS+1:0] diag_sum;
    logic [PIXEL_BITS:0]   horiz_sum;
    logic [PIXEL_BITS:0]   vert_sum;
    pix_t cross4;
    pix_t diag4;
    pix_t horiz2;
    pix_t vert2;
    pix_t ce;
    rgb_t res;
    cross_sum = (PIXEL_BITS+2)'(w[ra][1]) + (PIXEL_BITS+2)'(w[rb][1])
              + (PIXEL_BITS+2)'(w[rc][0]) + (PIXEL_BITS+2)'(w[rc][2]);
    diag_sum  = (PIXEL_BITS+2)'(w[ra][0]) + (PIXEL_BITS+2)'(w[ra][2])
              + (PIXEL_BITS+2)'(w[rb][0]) + (PIXEL_BITS+2)'(w[rb][2]);
    horiz_sum = (PIXEL_BITS+1)'(w[rc][0]) + (PIXEL_BITS+1)'(w[rc][2]);
    vert_sum  = (PIXEL_BITS+1)'(w[ra][1]) + (PIXEL_BITS+1)'(w[rb][1]);
    cross4 = cross_sum[PIXEL_BITS+1:2];
    diag4  = diag_sum[PIXEL_BITS+1:2];
    horiz2 = horiz_sum[PIXEL_BITS:1];
    vert2  = vert_sum[PIXEL_BITS:1];
    ce     = w[rc][1];
    res.frame_end = fe;
    if (ye && xe) begin
      res.red = ce;     res.green = cross4; res.blue = diag4;
    end else if (ye) begin
      res.red = horiz2; res.green = ce;     res.blue = vert2;
    end else if (xe) begin
      res.red = vert2;  res.green = ce;     res.blue = horiz2;
    end else begin
      res.red = diag4;  res.green = cross4; res.blue = ce;
    end
    return res;
  endfunction

endpackage

### sv/bdm_line_buf.sv
`timescale 1ns / 1ps

module bdm_line_buf #(
  parameter int MAX_WIDTH = bdm_pkg::MAX_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rd_en,
  input  logic [$clog2(MAX_WIDTH)-1:0] rd_addr,
  input  bdm_pkg::pix_t                new_pixel,
  input  logic                         owr_en,
  input  logic [$clog2(MAX_WIDTH)-1:0] owr_addr,
  input  bdm_pkg::pix_t                owr_data,
  output bdm_pkg::pix_t                top_r,
  output bdm_pkg::pix_t                mid_r
);

  bdm_pkg::pix_t older_mem [MAX_WIDTH];
  bdm_pkg::pix_t newer_mem [MAX_WIDTH];

  // The older row is written after the read of its column, when the window stage
  // loads that item; a read of the same column during the write takes its value.
  always_ff @(posedge clk) begin
    if (owr_en) begin
      older_mem[owr_addr] <= owr_data;
    end
    if (rd_en) begin
      if (owr_en && (owr_addr == rd_addr)) begin
        top_r <= owr_data;
      end else begin
        top_r <= older_mem[rd_addr];
      end
      mid_r <= newer_mem[rd_addr];
      newer_mem[rd_addr] <= new_pixel;
    end
  end

endmodule

### sv/bdm_window.sv
`timescale 1ns / 1ps

module bdm_window #(
  parameter int MAX_WIDTH = bdm_pkg::MAX_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         acc,
  input  bdm_pkg::acc_t                acc_info,
  input  logic [$clog2(MAX_WIDTH)-1:0] acc_x,
  input  bdm_pkg::pix_t                top,
  input  bdm_pkg::pix_t                mid,
  input  logic                         ld_ok,
  output logic                         held,
  output logic                         ld,
  output bdm_pkg::rgb_arr_t            ld_res,
  output logic [2:0]                   ld_cnt,
  output logic                         owr_en,
  output logic [$clog2(MAX_WIDTH)-1:0] owr_addr,
  output bdm_pkg::pix_t                owr_data
);

  localparam int XW = $clog2(MAX_WIDTH);

  logic                 s1_valid_r;
  bdm_pkg::acc_t        info_r;
  logic [XW-1:0]        x_r;
  bdm_pkg::win_t        win_r;
  bdm_pkg::win_t        win_nxt;
  bdm_pkg::win_t        win_a;
  bdm_pkg::win_t        win_b;
  bdm_pkg::pix_t [2:0]  col_in;
  bdm_pkg::rgb_t [3:0]  cand;
  logic [3:0]           flag;
  logic [1:0]           ra;
  logic [1:0]           rb_row;

  assign ld       = s1_valid_r && ld_ok;
  assign held     = s1_valid_r && !ld_ok;
  assign owr_en   = ld;
  assign owr_addr = x_r;
  assign owr_data = mid;

  always_comb begin
    col_in[0] = top;
    col_in[1] = mid;
    col_in[2] = info_r.pixel;
    for (int r = 0; r < 3; r++) begin
      if (info_r.x_first) begin
        win_a[r][0] = col_in[r];
        win_a[r][1] = col_in[r];
        win_a[r][2] = col_in[r];
      end else begin
        win_a[r][0] = win_r[r][1];
        win_a[r][1] = win_r[r][2];
        win_a[r][2] = col_in[r];
      end
      win_b[r][0] = win_a[r][1];
      win_b[r][1] = win_a[r][2];
      win_b[r][2] = win_a[r][2];
    end
    win_nxt = info_r.last_col ? win_b : win_a;

    ra     = info_r.y_eq1 ? bdm_pkg::ROW_MID : bdm_pkg::ROW_OLD;
    rb_row = info_r.y_ge1 ? bdm_pkg::ROW_MID : bdm_pkg::ROW_NEW;
    cand[0] = bdm_pkg::emit_pix(win_a, ra, bdm_pkg::ROW_MID, bdm_pkg::ROW_NEW,
                                info_r.y_odd, info_r.x_odd, 1'b0);
    cand[1] = bdm_pkg::emit_pix(win_a, rb_row, bdm_pkg::ROW_NEW, bdm_pkg::ROW_NEW,
                                !info_r.y_odd, info_r.x_odd, 1'b0);
    cand[2] = bdm_pkg::emit_pix(win_b, ra, bdm_pkg::ROW_MID, bdm_pkg::ROW_NEW,
                                info_r.y_odd, !info_r.x_odd, 1'b0);
    cand[3] = bdm_pkg::emit_pix(win_b, rb_row, bdm_pkg::ROW_NEW, bdm_pkg::ROW_NEW,
                                !info_r.y_odd, !info_r.x_odd, 1'b1);

    flag[0] = !info_r.x_first && info_r.y_ge1;
    flag[1] = !info_r.x_first && info_r.last_row;
    flag[2] = info_r.last_col && info_r.y_ge1;
    flag[3] = info_r.last_col && info_r.last_row;

    ld_res = cand;
    ld_cnt = 3'd0;
    for (int i = 0; i < 4; i++) begin
      if (flag[i]) begin
        ld_res[ld_cnt[1:0]] = cand[i];
        ld_cnt = ld_cnt + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      win_r      <= '0;
    end else begin
      if (acc) begin
        s1_valid_r <= 1'b1;
      end else if (ld) begin
        s1_valid_r <= 1'b0;
      end
      if (ld) begin
        win_r <= win_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      info_r <= acc_info;
      x_r    <= acc_x;
    end
  end

  a_no_accept_when_held: assert property (@(posedge clk) disable iff (!rst_n)
    held |-> !acc) else $error("item accepted while the window stage is held");

  a_held_keeps_item: assert property (@(posedge clk) disable iff (!rst_n)
    held |=> s1_valid_r && $stable(x_r) && $stable(info_r))
    else $error("held window stage lost its item");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ld |-> ld_cnt <= 3'd4) else $error("too many results for one item");

endmodule

### sv/bdm_out_q.sv
`timescale 1ns / 1ps

module bdm_out_q (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              ld,
  input  bdm_pkg::rgb_arr_t ld_res,
  input  logic [2:0]        ld_cnt,
  output logic              ld_ok,
  output logic              out_valid,
  input  logic              out_stall,
  output bdm_pkg::rgb_t     out_res
);

  bdm_pkg::rgb_arr_t res_r;
  bdm_pkg::rgb_arr_t res_nxt;
  logic [2:0]        cnt_r;
  logic [2:0]        cnt_nxt;
  logic              out_fire;

  assign out_valid = (cnt_r != 3'd0);
  assign out_fire  = out_valid && !out_stall;
  assign ld_ok     = (cnt_r == 3'd0) || ((cnt_r == 3'd1) && out_fire);
  assign out_res   = res_r[0];

  always_comb begin
    res_nxt = res_r;
    cnt_nxt = cnt_r;
    if (out_fire) begin
      for (int i = 0; i < bdm_pkg::MAX_RESULTS - 1; i++) begin
        res_nxt[i] = res_r[i+1];
      end
      cnt_nxt = cnt_r - 3'd1;
    end
    if (ld) begin
      res_nxt = ld_res;
      cnt_nxt = ld_cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 3'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 3'd4) else $error("result queue overfilled");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> $stable(cnt_r) && $stable(res_r[0]))
    else $error("stalled result changed");

  a_load_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    ld |-> ld_ok) else $error("results loaded over pending results");

endmodule

### sv/bilinear_demosaic_rggb.sv
`timescale 1ns / 1ps

// Bilinear demosaic of an RGGB Bayer stream, one raw sample per request on the
// in_ channel in raster order, full RGB pixels on the out_ channel.
// Image size comes from two registers written on the cfg_ channel (index 0 is
// the width, index 1 the height); write them only while the block is idle.
// Output lags the input by one row and one pixel. The last row of a frame is
// emitted while it arrives, so a sample of that row gives two pixels, and the
// last column of a row gives up to two more. frame_end marks the final pixel.
// Throughput is one sample per cycle while out_stall is low and each sample
// yields at most one pixel; otherwise the input stalls while the extra pixels
// drain, since the result queue sends one pixel per cycle when not stalled.
// A pixel reaches the outputs through the window stage register, then the queue.
// Reset clears counters, the window and the queue; the line stores are not
// cleared. When out_stall is high the front pixel holds and the input stalls
// as soon as the queue cannot take the next sample's results.

module bilinear_demosaic_rggb #(
  parameter int MAX_WIDTH = bdm_pkg::MAX_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [bdm_pkg::PIXEL_BITS-1:0] in_raw_pixel,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [bdm_pkg::PIXEL_BITS-1:0] out_red,
  output logic [bdm_pkg::PIXEL_BITS-1:0] out_green,
  output logic [bdm_pkg::PIXEL_BITS-1:0] out_blue,
  output logic                           out_frame_end,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic                           cfg_index,
  input  logic [bdm_pkg::CFG_BITS-1:0]   cfg_data
);

  localparam int XW = $clog2(MAX_WIDTH);
  localparam int EW = (XW + 1 > bdm_pkg::CFG_BITS) ? XW + 1 : bdm_pkg::CFG_BITS;
  localparam int RW = bdm_pkg::ROW_BITS;

  logic [bdm_pkg::CFG_BITS-1:0] width_r;
  logic [bdm_pkg::CFG_BITS-1:0] height_r;
  logic [XW-1:0]                col_r;
  logic [XW-1:0]                col_nxt;
  logic [RW-1:0]                row_r;
  logic [RW-1:0]                row_nxt;
  logic [EW-1:0]                w_ext;
  logic [EW-1:0]                w_eff;
  logic [RW-1:0]                h_eff;
  logic [XW-1:0]                x;
  logic [RW-1:0]                y;
  logic                         acc;
  bdm_pkg::acc_t                acc_info;
  bdm_pkg::pix_t                top;
  bdm_pkg::pix_t                mid;
  logic                         held;
  logic                         ld;
  logic                         ld_ok;
  bdm_pkg::rgb_arr_t            ld_res;
  logic [2:0]                   ld_cnt;
  logic                         owr_en;
  logic [XW-1:0]                owr_addr;
  bdm_pkg::pix_t                owr_data;
  bdm_pkg::rgb_t                out_res;

  assign cfg_ready = 1'b1;
  assign in_stall  = held;
  assign acc       = in_valid && !in_stall;

  always_comb begin
    w_ext = EW'(width_r);
    if (w_ext == '0) begin
      w_eff = EW'(1);
    end else if (w_ext > EW'(MAX_WIDTH)) begin
      w_eff = EW'(MAX_WIDTH);
    end else begin
      w_eff = w_ext;
    end
    h_eff = (height_r == '0) ? RW'(1) : RW'(height_r);
    x = (EW'(col_r) >= w_eff) ? '0 : col_r;
    y = (row_r >= h_eff) ? '0 : row_r;

    acc_info.x_first  = (x == '0);
    acc_info.last_col = (EW'(x) == w_eff - EW'(1));
    acc_info.last_row = (y == h_eff - RW'(1));
    acc_info.y_ge1    = (y != '0);
    acc_info.y_eq1    = (y == RW'(1));
    acc_info.y_odd    = y[0];
    acc_info.x_odd    = x[0];
    acc_info.pixel    = in_raw_pixel;

    if (acc_info.last_col) begin
      col_nxt = '0;
      row_nxt = acc_info.last_row ? '0 : y + RW'(1);
    end else begin
      col_nxt = x + XW'(1);
      row_nxt = y;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= bdm_pkg::WIDTH_RESET;
      height_r <= bdm_pkg::HEIGHT_RESET;
      col_r    <= '0;
      row_r    <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          bdm_pkg::CFG_IDX_WIDTH:  width_r  <= cfg_data;
          bdm_pkg::CFG_IDX_HEIGHT: height_r <= cfg_data;
          default: ;
        endcase
      end
      if (acc) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
      end
    end
  end

  bdm_line_buf #(.MAX_WIDTH(MAX_WIDTH)) u_line_buf (
    .clk       (clk),
    .rd_en     (acc),
    .rd_addr   (x),
    .new_pixel (in_raw_pixel),
    .owr_en    (owr_en),
    .owr_addr  (owr_addr),
    .owr_data  (owr_data),
    .top_r     (top),
    .mid_r     (mid)
  );

  bdm_window #(.MAX_WIDTH(MAX_WIDTH)) u_window (
    .clk      (clk),
    .rst_n    (rst_n),
    .acc      (acc),
    .acc_info (acc_info),
    .acc_x    (x),
    .top      (top),
    .mid      (mid),
    .ld_ok    (ld_ok),
    .held     (held),
    .ld       (ld),
    .ld_res   (ld_res),
    .ld_cnt   (ld_cnt),
    .owr_en   (owr_en),
    .owr_addr (owr_addr),
    .owr_data (owr_data)
  );

  bdm_out_q u_out_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .ld        (ld),
    .ld_res    (ld_res),
    .ld_cnt    (ld_cnt),
    .ld_ok     (ld_ok),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign out_red       = out_res.red;
  assign out_green     = out_res.green;
  assign out_blue      = out_res.blue;
  assign out_frame_end = out_res.frame_end;

endmodule
